### hw/rtl/atsb_pkg.sv
// shared types and constants for the adaptive time-slice budget block
package atsb_pkg;

  // operation codes of an input word
  typedef enum logic [2:0] {
    OP_BUDGET      = 3'd0,
    OP_COOP        = 3'd1,
    OP_OTHER       = 3'd2,
    OP_FORGET      = 3'd3,
    OP_FORGET_PROC = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNREG = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_CALC4,
    S_UPDATE,
    S_FIN
  } state_t;

  localparam logic [31:0] HOST_CHECK_NS = 32'd250000;
  localparam logic [31:0] SAFETY_NS     = 32'd100000;
  localparam logic [31:0] NO_DELAY      = 32'hFFFF_FFFF;
  localparam logic [31:0] RP_RESET      = 32'd1000000;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic calc1;
    logic calc2;
    logic calc3;
    logic calc4;
    logic update;
    logic load;
  } atsb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic is_budget;
  } atsb_sts_t;

endpackage

### hw/rtl/atsb_ctrl.sv
// controller state machine for the adaptive time-slice budget block
module atsb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output atsb_pkg::atsb_cmd_t cmd,
  input  atsb_pkg::atsb_sts_t sts
);
  import atsb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_done && sts.div_done) begin
          state_nxt = sts.is_budget ? S_CALC1 : S_UPDATE;
        end
      end
      S_CALC1:  state_nxt = S_CALC2;
      S_CALC2:  state_nxt = S_CALC3;
      S_CALC3:  state_nxt = S_CALC4;
      S_CALC4:  state_nxt = S_FIN;
      S_UPDATE: state_nxt = S_FIN;
      S_FIN:    if (can_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.start  = (state_r == S_IDLE) && in_valid;
    cmd.calc1  = (state_r == S_CALC1);
    cmd.calc2  = (state_r == S_CALC2);
    cmd.calc3  = (state_r == S_CALC3);
    cmd.calc4  = (state_r == S_CALC4);
    cmd.update = (state_r == S_UPDATE);
    cmd.load   = (state_r == S_FIN) && can_load;
    out_valid_nxt = cmd.load ? 1'b1 : (out_valid_r && out_stall);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/atsb_dp.sv
// datapath: history table scan, contention divider, budget arithmetic
module atsb_dp #(
  parameter int SLOTS     = 64,
  parameter int MAX_LEVEL = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  atsb_pkg::atsb_cmd_t cmd,
  output atsb_pkg::atsb_sts_t sts,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic [2:0]         in_op,
  input  logic [31:0]        in_process_id,
  input  logic [31:0]        in_thread_id,
  input  logic               in_registered,
  input  logic [6:0]         in_scheduled_priority,
  input  logic [6:0]         in_highest_priority,
  input  logic [11:0]        in_competitor_count,
  input  logic               in_latency_sensitive,
  input  logic [31:0]        in_jit_p99,
  input  logic [31:0]        in_host_delay,
  input  logic [31:0]        in_guest_delay,
  output logic [31:0]        out_budget_ns,
  output logic [1:0]         out_status
);
  import atsb_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
  localparam logic [7:0] MAXL = 8'(MAX_LEVEL);

  // response period register
  logic [31:0] rp_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      rp_r <= RP_RESET;
    else if (cfg_we) rp_r <= cfg_wdata;
  end

  // captured word and derived budgets
  logic [2:0]  op_r;
  logic [63:0] key_r;
  logic        reg_r, lat_r;
  logic [6:0]  sp_r, hp_r;
  logic [11:0] cc_r;
  logic [31:0] jit_r, hd_r, gd_r;
  logic [31:0] minb_r, init_r, latb_r, thr_r;
  logic [31:0] minb_c, init_c, latb_c, thr_c, rp_q3;

  always_comb begin
    minb_c = (rp_r < HOST_CHECK_NS) ? rp_r : HOST_CHECK_NS;
    init_c = (minb_c > {2'b0, rp_r[31:2]}) ? minb_c : {2'b0, rp_r[31:2]};
    latb_c = (init_c > {1'b0, rp_r[31:1]}) ? init_c : {1'b0, rp_r[31:1]};
    rp_q3  = rp_r - {2'b0, rp_r[31:2]};
    thr_c  = (latb_c > rp_q3) ? latb_c : rp_q3;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_op;
      key_r  <= {in_process_id, in_thread_id};
      reg_r  <= in_registered;
      lat_r  <= in_latency_sensitive;
      sp_r   <= in_scheduled_priority;
      hp_r   <= in_highest_priority;
      cc_r   <= in_competitor_count;
      jit_r  <= in_jit_p99;
      hd_r   <= in_host_delay;
      gd_r   <= in_guest_delay;
      minb_r <= minb_c;
      init_r <= init_c;
      latb_r <= latb_c;
      thr_r  <= thr_c;
    end
  end

  // restoring divider: period over contenders plus one, one bit a cycle
  logic [12:0] div_r, rem_r;
  logic [31:0] quo_r;
  logic [4:0]  div_cnt_r;
  logic        div_busy_r;
  logic [13:0] trial;
  logic        trial_ge;

  assign trial    = {rem_r, quo_r[31]};
  assign trial_ge = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && (div_cnt_r == 5'd31)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_r     <= {1'b0, in_competitor_count} + 13'd1;
      rem_r     <= '0;
      quo_r     <= rp_r;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      rem_r     <= trial_ge ? 13'(trial - {1'b0, div_r}) : trial[12:0];
      quo_r     <= {quo_r[30:0], trial_ge};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // history table storage
  logic [63:0]    key_mem [SLOTS];
  logic [7:0]     lvl_mem [SLOTS];
  logic [SLOTS-1:0] valid_r;

  // scan pipeline: address issue then compare
  logic [AW-1:0] scan_idx_r, cmp_idx_r;
  logic          iss_r, cmp_vld_r;
  logic [63:0]   rd_key_r;
  logic [7:0]    rd_lvl_r;
  logic          hit_r, free_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;
  logic [7:0]    hit_lvl_r;
  logic          cmp_v, key_match, pid_match;

  assign cmp_v     = valid_r[cmp_idx_r];
  assign key_match = (rd_key_r == key_r);
  assign pid_match = (rd_key_r[63:32] == key_r[63:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r     <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.start)                                iss_r <= 1'b1;
      else if (iss_r && (scan_idx_r == LAST_IDX))   iss_r <= 1'b0;
      cmp_vld_r <= iss_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r  <= key_mem[scan_idx_r];
    rd_lvl_r  <= lvl_mem[scan_idx_r];
    cmp_idx_r <= scan_idx_r;
    if (cmd.start) begin
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      if (iss_r) scan_idx_r <= scan_idx_r + AW'(1);
      if (cmp_vld_r) begin
        if (cmp_v && key_match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
          hit_lvl_r <= rd_lvl_r;
        end
        if (!cmp_v && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end
    end
  end

  // table update decode
  logic          key_we, lvl_we, vset, vclr, pclr;
  logic [AW-1:0] wr_idx;
  logic [7:0]    lvl_wdata;

  always_comb begin
    key_we    = 1'b0;
    lvl_we    = 1'b0;
    vset      = 1'b0;
    vclr      = 1'b0;
    wr_idx    = hit_idx_r;
    lvl_wdata = hit_lvl_r;
    pclr      = cmp_vld_r && (op_r == OP_FORGET_PROC) && cmp_v && pid_match;
    if (cmd.update) begin
      unique case (op_r)
        OP_COOP: begin
          if (hit_r) begin
            lvl_we    = 1'b1;
            lvl_wdata = (hit_lvl_r >= MAXL) ? MAXL : hit_lvl_r + 8'd1;
          end else if (free_r) begin
            wr_idx    = free_idx_r;
            key_we    = 1'b1;
            lvl_we    = 1'b1;
            vset      = 1'b1;
            lvl_wdata = 8'd1;
          end
        end
        OP_OTHER: begin
          if (hit_r) begin
            if (hit_lvl_r > 8'd1) begin
              lvl_we    = 1'b1;
              lvl_wdata = hit_lvl_r - 8'd1;
            end else begin
              vclr = 1'b1;
            end
          end
        end
        OP_FORGET: vclr = hit_r;
        default: ;
      endcase
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_idx] <= key_r;
    if (lvl_we) lvl_mem[wr_idx] <= lvl_wdata;
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (pclr) valid_r[cmp_idx_r] <= 1'b0;
      if (vset) valid_r[wr_idx] <= 1'b1;
      if (vclr) valid_r[wr_idx] <= 1'b0;
    end
  end

  // deadline cut for one delay
  function automatic logic [31:0] cut_delay(input logic [31:0] res, input logic [31:0] d,
                                            input logic [32:0] guard, input logic [31:0] minb);
    logic [31:0] diff, m;
    diff = d - guard[31:0];
    m    = (diff > minb) ? diff : minb;
    if (d == NO_DELAY)             cut_delay = res;
    else if ({1'b0, d} <= guard)   cut_delay = minb;
    else                           cut_delay = (res < m) ? res : m;
  endfunction

  // budget arithmetic stages
  logic [31:0] cap_r, res_r, cap_c, share, adapt, floorv, res2, res4a, res4b;
  logic [40:0] prod_r;
  logic [32:0] guard_r, gmax;
  logic [8:0]  lvl_p1;

  always_comb begin
    share = (quo_r > init_r) ? quo_r : init_r;
    cap_c = thr_r;
    if (cc_r != 12'd0 && share < cap_c) cap_c = share;
    if (hp_r > sp_r) cap_c = init_r;
    if (lat_r && latb_r < cap_c) cap_c = latb_r;
    lvl_p1 = {1'b0, hit_r ? hit_lvl_r : 8'd0} + 9'd1;
    adapt  = (prod_r < {9'b0, thr_r}) ? prod_r[31:0] : thr_r;
    gmax   = (guard_r > {1'b0, init_r}) ? guard_r : {1'b0, init_r};
    floorv = (gmax < {1'b0, cap_r}) ? gmax[31:0] : cap_r;
    res2   = (adapt > floorv) ? adapt : floorv;
    if (cap_r < res2) res2 = cap_r;
    res4a  = cut_delay(res_r, gd_r, guard_r, minb_r);
    res4b  = (res4a < thr_r) ? res4a : thr_r;
    if (minb_r > res4b) res4b = minb_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      cap_r   <= cap_c;
      prod_r  <= 41'(init_r) * 41'(lvl_p1);
      guard_r <= {1'b0, jit_r} + {1'b0, SAFETY_NS};
    end
    if (cmd.calc2) res_r <= res2;
    if (cmd.calc3) res_r <= cut_delay(res_r, hd_r, guard_r, minb_r);
    if (cmd.calc4) res_r <= res4b;
  end

  // output register
  logic [31:0] budget_r;
  logic [1:0]  status_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (op_r == OP_BUDGET && reg_r) budget_r <= res_r;
      else                            budget_r <= '0;
      if (op_r == OP_BUDGET && !reg_r)              status_r <= ST_UNREG;
      else if (op_r == OP_COOP && !hit_r && !free_r) status_r <= ST_FULL;
      else                                           status_r <= ST_OK;
    end
  end

  assign out_budget_ns = budget_r;
  assign out_status    = status_r;

  assign sts.scan_done = !iss_r && !cmp_vld_r;
  assign sts.div_done  = !div_busy_r;
  assign sts.is_budget = (op_r == OP_BUDGET);

endmodule

### hw/rtl/adaptive_time_slice_budget.sv
// Adaptive time-slice budget: takes one word at a time and returns one result word for it.
// Every word scans the whole history table one entry per cycle; its result is held in the
// output register while out_stall is high, and the next word can be taken in the cycle after
// the result is loaded. The 32-step contention divider runs alongside the scan. The
// response period may be written only while idle; the table is empty right after reset
// with no clearing pass.
module adaptive_time_slice_budget #(
  parameter int HISTORY_SLOTS = 64,
  parameter int MAX_LEVEL     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_process_id,
  input  logic [31:0] in_thread_id,
  input  logic        in_registered,
  input  logic [6:0]  in_scheduled_priority,
  input  logic [6:0]  in_highest_priority,
  input  logic [11:0] in_competitor_count,
  input  logic        in_latency_sensitive,
  input  logic [31:0] in_jit_p99,
  input  logic [31:0] in_host_delay,
  input  logic [31:0] in_guest_delay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_budget_ns,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import atsb_pkg::*;

  atsb_cmd_t cmd;
  atsb_sts_t sts;

  // control
  atsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  atsb_dp #(
    .SLOTS     (HISTORY_SLOTS),
    .MAX_LEVEL (MAX_LEVEL)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_op                 (in_op),
    .in_process_id         (in_process_id),
    .in_thread_id          (in_thread_id),
    .in_registered         (in_registered),
    .in_scheduled_priority (in_scheduled_priority),
    .in_highest_priority   (in_highest_priority),
    .in_competitor_count   (in_competitor_count),
    .in_latency_sensitive  (in_latency_sensitive),
    .in_jit_p99            (in_jit_p99),
    .in_host_delay         (in_host_delay),
    .in_guest_delay        (in_guest_delay),
    .out_budget_ns         (out_budget_ns),
    .out_status            (out_status)
  );

endmodule

### sim/tb_adaptive_time_slice_budget.sv
// self-checking testbench for the adaptive time-slice budget block
`timescale 1ns / 100ps

module tb_adaptive_time_slice_budget;
  import atsb_pkg::*;

  localparam int SLOTS = 64;
  localparam int TOP_LEVEL = 8;
  localparam int CYCLE_LIMIT = 400000;

  // op codes with no defined operation
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // one input word
  typedef struct {
    logic [2:0]  op;
    logic [31:0] pid;
    logic [31:0] tid;
    logic        registered;
    logic [6:0]  sched_pri;
    logic [6:0]  high_pri;
    logic [11:0] competitors;
    logic        lat_sens;
    logic [31:0] jit;
    logic [31:0] host_dly;
    logic [31:0] guest_dly;
  } word_t;

  // one result word
  typedef struct {
    logic [31:0] budget;
    logic [1:0]  status;
  } result_t;

  // directed table row: word plus optional typed-in result
  typedef struct {
    word_t   w;
    logic    typed;
    result_t res;
  } row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [31:0] in_process_id = '0;
  logic [31:0] in_thread_id = '0;
  logic        in_registered = 0;
  logic [6:0]  in_scheduled_priority = '0;
  logic [6:0]  in_highest_priority = '0;
  logic [11:0] in_competitor_count = '0;
  logic        in_latency_sensitive = 0;
  logic [31:0] in_jit_p99 = '0;
  logic [31:0] in_host_delay = '0;
  logic [31:0] in_guest_delay = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] out_budget_ns;
  logic [1:0]  out_status;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;

  adaptive_time_slice_budget u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_process_id(in_process_id), .in_thread_id(in_thread_id),
    .in_registered(in_registered), .in_scheduled_priority(in_scheduled_priority),
    .in_highest_priority(in_highest_priority),
    .in_competitor_count(in_competitor_count),
    .in_latency_sensitive(in_latency_sensitive), .in_jit_p99(in_jit_p99),
    .in_host_delay(in_host_delay), .in_guest_delay(in_guest_delay),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_budget_ns(out_budget_ns), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [63:0] hist_key [SLOTS];
  logic [7:0]  hist_level [SLOTS];
  logic [31:0] period;

  result_t     pending_results[$];
  int          errors = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          budgets_seen = 0;
  int          full_seen = 0;
  longint      cycles = 0;
  logic        hold_off = 0;
  int          hold_cycles = 0;
  logic        rx_random = 1;
  int          rx_wait = 0;

  function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
    return a < b ? a : b;
  endfunction

  function automatic logic [63:0] max64(logic [63:0] a, logic [63:0] b);
    return a > b ? a : b;
  endfunction

  function automatic int slot_of(logic [63:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (hist_level[i] != 0 && hist_key[i] == key) return i;
    return -1;
  endfunction

  // deadline cut on the running budget
  function automatic logic [63:0] cut_deadline(logic [63:0] b, logic [31:0] d,
                                               logic [63:0] guard, logic [63:0] minb);
    if (d == NO_DELAY) return b;
    if ({32'd0, d} <= guard) return minb;
    return min64(b, max64(minb, {32'd0, d} - guard));
  endfunction

  // compute the result for a word and update the history table
  function automatic result_t budget_predict(word_t w);
    result_t r;
    logic [63:0] key, rp, minb, init, latb, thr, cap, adapt, guard, floorv, b;
    logic [63:0] level;
    int s;
    r.budget = '0;
    r.status = ST_OK;
    key = {w.pid, w.tid};
    s = slot_of(key);
    case (w.op)
      OP_BUDGET: begin
        if (!w.registered) begin
          r.status = ST_UNREG;
        end else begin
          rp = {32'd0, period};
          minb = min64(rp, {32'd0, HOST_CHECK_NS});
          init = max64(minb, rp / 4);
          latb = max64(init, rp / 2);
          thr = max64(latb, rp - rp / 4);
          level = (s >= 0) ? 64'(hist_level[s]) : 64'd0;
          cap = thr;
          if (w.competitors != 0) cap = min64(cap, max64(init, rp / (w.competitors + 64'd1)));
          if (w.high_pri > w.sched_pri) cap = init;
          if (w.lat_sens) cap = min64(cap, latb);
          adapt = min64(thr, init * (level + 64'd1));
          guard = {32'd0, w.jit} + {32'd0, SAFETY_NS};
          floorv = min64(cap, max64(init, guard));
          b = min64(cap, max64(adapt, floorv));
          b = cut_deadline(b, w.host_dly, guard, minb);
          b = cut_deadline(b, w.guest_dly, guard, minb);
          b = max64(minb, min64(b, thr));
          r.budget = b[31:0];
        end
      end
      OP_COOP: begin
        if (s < 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (hist_level[i] == 0) begin
              s = i;
              break;
            end
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            hist_key[s] = key;
            hist_level[s] = 8'd1;
          end
        end else if (hist_level[s] < TOP_LEVEL) begin
          hist_level[s] = hist_level[s] + 8'd1;
        end
      end
      OP_OTHER: begin
        if (s >= 0) hist_level[s] = hist_level[s] > 8'd1 ? hist_level[s] - 8'd1 : 8'd0;
      end
      OP_FORGET: begin
        if (s >= 0) hist_level[s] = 8'd0;
      end
      OP_FORGET_PROC: begin
        for (int i = 0; i < SLOTS; i++)
          if (hist_level[i] != 0 && hist_key[i][63:32] == w.pid) hist_level[i] = 8'd0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: budget %0d status %0d",
               out_budget_ns, out_status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_budget_ns !== exp_r.budget) begin
          $error("budget_ns expected %0d actual %0d", exp_r.budget, out_budget_ns);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          errors++;
        end
        if (exp_r.status == ST_OK && exp_r.budget != 0) budgets_seen++;
        if (exp_r.status == ST_FULL) full_seen++;
      end
    end
  end

  // receiver stall: a random wait drawn per word, or a long hold-off
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles + 1;
    end else if (!rx_random) begin
      out_stall <= 0;
    end else if (out_valid && rx_wait > 0) begin
      out_stall <= 1;
      rx_wait <= rx_wait - 1;
    end else begin
      out_stall <= 0;
      if (out_valid) rx_wait <= $urandom_range(0, 6);
    end
  end

  // offer one word and wait until it is taken; valid stays up for a following word
  task automatic send_word(word_t w);
    in_op <= w.op;
    in_process_id <= w.pid;
    in_thread_id <= w.tid;
    in_registered <= w.registered;
    in_scheduled_priority <= w.sched_pri;
    in_highest_priority <= w.high_pri;
    in_competitor_count <= w.competitors;
    in_latency_sensitive <= w.lat_sens;
    in_jit_p99 <= w.jit;
    in_host_delay <= w.host_dly;
    in_guest_delay <= w.guest_dly;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(budget_predict(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap(int max_gap);
    int n;
    n = $urandom_range(0, max_gap);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_period(logic [31:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    period = v;
  endtask

  function automatic word_t make_word(logic [2:0] op, logic [31:0] pid, logic [31:0] tid);
    word_t w;
    w.op = op;
    w.pid = pid;
    w.tid = tid;
    w.registered = 1;
    w.sched_pri = 7'd10;
    w.high_pri = 7'd0;
    w.competitors = '0;
    w.lat_sens = 0;
    w.jit = '0;
    w.host_dly = NO_DELAY;
    w.guest_dly = NO_DELAY;
    return w;
  endfunction

  // random word with small key pools so the table sees reuse
  function automatic word_t random_word(bit fill_mode);
    word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.op = pick < 40 ? OP_BUDGET : pick < 70 ? OP_COOP : pick < 88 ? OP_OTHER :
           pick < 95 ? OP_FORGET : pick < 98 ? OP_FORGET_PROC :
           3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (fill_mode) w.op = OP_COOP;
    w.pid = ($urandom_range(0, 9) == 0) ? $urandom :
            (($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'd0) | 32'($urandom_range(0, 3)));
    w.tid = ($urandom_range(0, 9) == 0) ? $urandom : {$urandom_range(0, 1) ? 32'h8000_0000 : 32'd0}
            | 32'($urandom_range(0, fill_mode ? 40 : 7));
    w.registered = $urandom_range(0, 9) != 0;
    w.sched_pri = 7'($urandom);
    w.high_pri = $urandom_range(0, 1) ? w.sched_pri : 7'($urandom);
    case ($urandom_range(0, 3))
      0: w.competitors = '0;
      1: w.competitors = 12'($urandom_range(1, 8));
      2: w.competitors = 12'($urandom);
      default: w.competitors = 12'hFFF;
    endcase
    w.lat_sens = 1'($urandom);
    case ($urandom_range(0, 3))
      0: w.jit = 32'($urandom_range(0, 400000));
      1: w.jit = $urandom;
      2: w.jit = 32'hFFFF_FFFF;
      default: w.jit = '0;
    endcase
    w.host_dly = $urandom_range(0, 2) == 0 ? NO_DELAY :
                 $urandom_range(0, 1) ? 32'($urandom_range(0, 2000000)) : $urandom;
    w.guest_dly = $urandom_range(0, 2) == 0 ? NO_DELAY :
                  $urandom_range(0, 1) ? 32'($urandom_range(0, 2000000)) : $urandom;
    return w;
  endfunction

  row_t dir_rows[$];

  function automatic row_t mk_row(word_t w, logic typed, logic [31:0] b, logic [1:0] st);
    row_t r;
    r.w = w;
    r.typed = typed;
    r.res.budget = b;
    r.res.status = st;
    return r;
  endfunction

  initial begin
    word_t w;
    result_t pred;
    logic [31:0] periods [5];
    period = RP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      hist_key[i] = '0;
      hist_level[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed table at reset period (1 ms): budgets read off directly
    w = make_word(OP_BUDGET, 32'd1, 32'd1);
    dir_rows.push_back(mk_row(w, 1, 32'd250000, ST_OK));           // no history, no cap
    w.registered = 0;
    dir_rows.push_back(mk_row(w, 1, 32'd0, ST_UNREG));              // unregistered
    w = make_word(OP_BUDGET, 32'd1, 32'd1);
    w.high_pri = 7'd127;
    w.sched_pri = 7'd0;
    dir_rows.push_back(mk_row(w, 1, 32'd250000, ST_OK));           // higher priority waits
    w = make_word(OP_BUDGET, 32'd1, 32'd1);
    w.lat_sens = 1;
    dir_rows.push_back(mk_row(w, 1, 32'd250000, ST_OK));           // latency sensitive
    w = make_word(OP_BUDGET, 32'd1, 32'd1);
    w.competitors = 12'hFFF;
    dir_rows.push_back(mk_row(w, 1, 32'd250000, ST_OK));           // many contenders
    w = make_word(OP_BUDGET, 32'd1, 32'd1);
    w.host_dly = 32'd0;
    dir_rows.push_back(mk_row(w, 1, 32'd250000, ST_OK));           // deadline inside guard
    w = make_word(OP_BUDGET, 32'd1, 32'd1);
    w.guest_dly = 32'hFFFF_FFFE;
    w.jit = 32'hFFFF_FFFF;
    w.sched_pri = 7'd127;
    dir_rows.push_back(mk_row(w, 1, 32'd250000, ST_OK));           // saturated jit time
    // history build-up, then budget grows
    for (int k = 0; k < 10; k++)
      dir_rows.push_back(mk_row(make_word(OP_COOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 32'd0,
                                ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_BUDGET, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, 32'd0,
                              ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 32'd0,
                              ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_OTHER, 32'd5, 32'd5), 1, 32'd0, ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_FORGET, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 32'd0,
                              ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_COOP, 32'd7, 32'd0), 1, 32'd0, ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_FORGET_PROC, 32'd7, 32'd0), 1, 32'd0, ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_SPARE_HI, 32'd7, 32'd0), 1, 32'd0, ST_OK));
    dir_rows.push_back(mk_row(make_word(OP_SPARE_LO, 32'd0, 32'd0), 1, 32'd0, ST_OK));

    foreach (dir_rows[i]) begin
      w = dir_rows[i].w;
      if (dir_rows[i].typed) begin
        pred = budget_predict(w);
        if ((pred.budget !== dir_rows[i].res.budget) ||
            (pred.status !== dir_rows[i].res.status)) begin
          $error("directed row %0d: table budget %0d status %0d predictor %0d %0d",
                 i, dir_rows[i].res.budget, dir_rows[i].res.status, pred.budget, pred.status);
          errors++;
        end
        // undo the predictor's table effect by replaying from a snapshot is not
        // needed: budget rows leave the table alone, and table rows are replayed below
      end
    end
    // replay table on a clean copy so the checker sees the true order
    for (int i = 0; i < SLOTS; i++) hist_level[i] = '0;
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w);
      sender_gap(6);
    end

    // fill the table to hit the full status, then clear it
    wait_drained();
    for (int k = 0; k < SLOTS + 2; k++)
      send_word(make_word(OP_COOP, 32'd9, 32'(k)));
    send_word(make_word(OP_FORGET_PROC, 32'd9, 32'd0));

    // long receiver hold-off while words keep coming
    hold_off = 1;
    fork
      begin
        for (int k = 0; k < 6; k++) send_word(random_word(0));
      end
      begin
        while (hold_cycles < 300) @(negedge clk);
        hold_off = 0;
      end
    join

    // random phases over several periods, extremes included
    periods[0] = 32'd1;
    periods[1] = 32'hFFFF_FFFF;
    periods[2] = 32'd250000;
    periods[3] = 32'($urandom_range(1, 5000000));
    periods[4] = RP_RESET;
    for (int p = 0; p < 5; p++) begin
      write_period(periods[p]);
      rx_random = (p != 2);
      for (int k = 0; k < 130; k++) begin
        send_word(random_word(k > 100 && p == 1));
        if (p != 2) sender_gap(6);
      end
    end

    wait_drained();
    $display("sent %0d words, %0d results checked (%0d nonzero budgets, %0d table-full)",
             words_sent, results_seen, budgets_seen, full_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
